// ===== rtl/core/psrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psrt_pkg;

  // Field widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned QUAT_W  = 16;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Fixed-point shifts: Q16.16 scale product, first and second cross product.
  localparam int unsigned SCALE_SH  = 16;
  localparam int unsigned CROSS1_SH = 14;
  localparam int unsigned CROSS2_SH = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd6;

  // Reset values.
  localparam logic [COORD_W-1:0] SCALE_ONE     = 32'h0001_0000;
  localparam logic [CFG_W-1:0]   QUAT_IDENTITY = 64'h4000_0000_0000_0000;

  // Input beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  // Result beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      overflow;
  } result_t;

  // Vector part of the rotation quaternion.
  typedef struct packed {
    logic signed [QUAT_W-1:0] qx;
    logic signed [QUAT_W-1:0] qy;
    logic signed [QUAT_W-1:0] qz;
  } qvec_t;

endpackage

`default_nettype wire

// ===== rtl/core/psrt_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-axis scaling: one stage of 32x32 multiplies, one stage of shift and saturate.
module psrt_scale import psrt_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire point_t                     point_i,
  input  wire logic [3*COORD_W-1:0]       scale_i,
  output logic                            valid_o,
  output logic [3*COORD_W-1:0]            v_o,
  output logic                            ovf_o
);

  localparam int unsigned PW = 2 * COORD_W;
  localparam int unsigned SW = PW - SCALE_SH;

  logic signed [COORD_W-1:0] pt [3];
  logic signed [PW-1:0]      prod_d [3];
  logic signed [PW-1:0]      prod_q [3];
  logic                      valid1_q;
  logic signed [PW-1:0]      shifted [3];
  logic [3*COORD_W-1:0]      v_d;
  logic [3*COORD_W-1:0]      v_q;
  logic                      ovf_d;
  logic                      ovf_q;
  logic                      valid2_q;

  // Stage one: full-width products.
  always_comb begin
    pt[0] = point_i.point_x;
    pt[1] = point_i.point_y;
    pt[2] = point_i.point_z;
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = PW'(pt[k]) * PW'($signed(scale_i[k*COORD_W +: COORD_W]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  // Stage two: floor shift by 16 and saturate to 32 bits.
  always_comb begin
    ovf_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      shifted[k] = prod_q[k] >>> SCALE_SH;
      if (shifted[k][SW-1:COORD_W-1] == '0 || shifted[k][SW-1:COORD_W-1] == '1) begin
        v_d[k*COORD_W +: COORD_W] = shifted[k][COORD_W-1:0];
      end else begin
        ovf_d = 1'b1;
        v_d[k*COORD_W +: COORD_W] = shifted[k][SW-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                                     : {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    ovf_q <= ovf_d;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o = valid2_q;
  assign v_o     = v_q;
  assign ovf_o   = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/psrt_cross.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cross product q x b followed by a floor shift: one stage of six multiplies,
// one stage of subtract and shift.
module psrt_cross import psrt_pkg::*; #(
  parameter int unsigned BW = COORD_W,
  parameter int unsigned SH = CROSS1_SH,
  localparam int unsigned OW = BW + QUAT_W + 1 - SH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire qvec_t           q_i,
  input  wire logic [3*BW-1:0] b_i,
  output logic                 valid_o,
  output logic [3*OW-1:0]      r_o
);

  localparam int unsigned PW = BW + QUAT_W;

  logic signed [BW-1:0]   bs [3];
  logic signed [PW-1:0]   prod_d [6];
  logic signed [PW-1:0]   prod_q [6];
  logic                   valid1_q;
  logic signed [PW:0]     diff [3];
  logic signed [PW:0]     shifted [3];
  logic [3*OW-1:0]        r_d;
  logic [3*OW-1:0]        r_q;
  logic                   valid2_q;

  // Stage one: the six products of the cross product.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bs[k] = $signed(b_i[k*BW +: BW]);
    end
    prod_d[0] = PW'(q_i.qy) * PW'(bs[2]);
    prod_d[1] = PW'(q_i.qz) * PW'(bs[1]);
    prod_d[2] = PW'(q_i.qz) * PW'(bs[0]);
    prod_d[3] = PW'(q_i.qx) * PW'(bs[2]);
    prod_d[4] = PW'(q_i.qx) * PW'(bs[1]);
    prod_d[5] = PW'(q_i.qy) * PW'(bs[0]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  // Stage two: differences, then floor shift.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]    = (PW+1)'(prod_q[2*k]) - (PW+1)'(prod_q[2*k+1]);
      shifted[k] = diff[k] >>> SH;
      r_d[k*OW +: OW] = shifted[k][OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  assign valid_o = valid2_q;
  assign r_o     = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/point_scale_rotate_translate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Point transform: scale per axis, rotate by a quaternion, then translate.
// Input channel: a point beat is taken at a rising edge where start is high
// and busy is low. busy is high only for the first cycle after reset, so one
// point can be taken every cycle.
// Result channel: each result beat shows on result_o for exactly one cycle
// with out_strobe_o high, once its point has passed the register stages. The
// receiver cannot stall; results leave in the order the points came in.
// One point is taken per cycle; the path runs through seven register
// stages: scale multiply, scale saturate, two stages for each of the two
// cross products (the w term runs beside the second), and the final sum.
// Configuration: write beats on the cfg channel (index, data) are always
// taken; cfg_ready_o is tied high. Registers may change only while no point
// is in flight. Unknown indexes are ignored.
// Reset: asynchronous, active low. All valid bits clear, so any point in
// flight is dropped; registers return to unit scale, identity rotation and
// zero offset.
module point_scale_rotate_translate_core import psrt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire point_t               point_i,
  output logic                      out_strobe_o,
  output result_t                   result_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned C_W   = COORD_W + QUAT_W + 1 - CROSS1_SH;
  localparam int unsigned D_W   = C_W + QUAT_W + 1 - CROSS2_SH;
  localparam int unsigned WC_PW = C_W + QUAT_W;
  localparam int unsigned WC_W  = WC_PW - CROSS2_SH;
  localparam int unsigned SUM_W = D_W + 3;
  localparam int unsigned DLY   = 4;

  logic [3*COORD_W-1:0] scale_q;
  logic [CFG_W-1:0]     quat_q;
  logic [3*COORD_W-1:0] offset_q;
  logic                 busy_q;
  logic                 accept;
  qvec_t                qv;
  logic signed [QUAT_W-1:0] qw;

  logic                 s_valid;
  logic [3*COORD_W-1:0] s_v;
  logic                 s_ovf;

  logic                 c_valid;
  logic [3*C_W-1:0]     c_vec;

  logic                 d_valid;
  logic [3*D_W-1:0]     d_vec;

  logic [3*COORD_W-1:0] v_pipe_q [DLY];
  logic                 ovf_pipe_q [DLY];

  logic signed [WC_PW-1:0] wc_prod_d [3];
  logic signed [WC_PW-1:0] wc_prod_q [3];
  logic signed [WC_PW-1:0] wc_sh [3];
  logic signed [WC_W-1:0]  wc_q [3];

  logic signed [SUM_W-1:0] sum [3];
  result_t              res_d;
  result_t              res_q;
  logic                 strobe_q;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;
  assign qw    = $signed(quat_q[63:48]);
  assign qv.qx = $signed(quat_q[47:32]);
  assign qv.qy = $signed(quat_q[31:16]);
  assign qv.qz = $signed(quat_q[15:0]);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= {SCALE_ONE, SCALE_ONE, SCALE_ONE};
      quat_q   <= QUAT_IDENTITY;
      offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SCALE_X:  scale_q[0*COORD_W +: COORD_W]  <= cfg_data_i[COORD_W-1:0];
        REG_SCALE_Y:  scale_q[1*COORD_W +: COORD_W]  <= cfg_data_i[COORD_W-1:0];
        REG_SCALE_Z:  scale_q[2*COORD_W +: COORD_W]  <= cfg_data_i[COORD_W-1:0];
        REG_ROTATION: quat_q                         <= cfg_data_i;
        REG_OFFSET_X: offset_q[0*COORD_W +: COORD_W] <= cfg_data_i[COORD_W-1:0];
        REG_OFFSET_Y: offset_q[1*COORD_W +: COORD_W] <= cfg_data_i[COORD_W-1:0];
        REG_OFFSET_Z: offset_q[2*COORD_W +: COORD_W] <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Busy for one cycle after reset so no beat is taken while the pipe comes up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  // Stages one and two: scaling.
  psrt_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .point_i (point_i),
    .scale_i (scale_q),
    .valid_o (s_valid),
    .v_o     (s_v),
    .ovf_o   (s_ovf)
  );

  // Stages three and four: c = q x v.
  psrt_cross #(
    .BW (COORD_W),
    .SH (CROSS1_SH)
  ) u_cross1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .q_i     (qv),
    .b_i     (s_v),
    .valid_o (c_valid),
    .r_o     (c_vec)
  );

  // Stages five and six: d = 2 q x c.
  psrt_cross #(
    .BW (C_W),
    .SH (CROSS2_SH)
  ) u_cross2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .q_i     (qv),
    .b_i     (c_vec),
    .valid_o (d_valid),
    .r_o     (d_vec)
  );

  // The doubled w term runs beside the second cross product.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wc_prod_d[k] = WC_PW'(qw) * WC_PW'($signed(c_vec[k*C_W +: C_W]));
      wc_sh[k]     = wc_prod_q[k] >>> CROSS2_SH;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      wc_prod_q[k] <= wc_prod_d[k];
      wc_q[k]      <= wc_sh[k][WC_W-1:0];
    end
  end

  // Scaled vector and scale overflow wait for the rotation terms.
  always_ff @(posedge clk_i) begin
    v_pipe_q[0]   <= s_v;
    ovf_pipe_q[0] <= s_ovf;
    for (int k = 1; k < DLY; k++) begin
      v_pipe_q[k]   <= v_pipe_q[k-1];
      ovf_pipe_q[k] <= ovf_pipe_q[k-1];
    end
  end

  // Stage seven: final sum, saturation and overflow flag.
  always_comb begin
    res_d.overflow = ovf_pipe_q[DLY-1];
    for (int k = 0; k < 3; k++) begin
      sum[k] = SUM_W'($signed(v_pipe_q[DLY-1][k*COORD_W +: COORD_W]))
             + SUM_W'(wc_q[k])
             + SUM_W'($signed(d_vec[k*D_W +: D_W]))
             + SUM_W'($signed(offset_q[k*COORD_W +: COORD_W]));
    end
    {res_d.out_x, res_d.out_y, res_d.out_z} = '0;
    for (int k = 0; k < 3; k++) begin
      logic [COORD_W-1:0] sat;
      if (sum[k][SUM_W-1:COORD_W-1] == '0 || sum[k][SUM_W-1:COORD_W-1] == '1) begin
        sat = sum[k][COORD_W-1:0];
      end else begin
        res_d.overflow = 1'b1;
        sat = sum[k][SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                              : {1'b0, {(COORD_W-1){1'b1}}};
      end
      case (k)
        0:       res_d.out_x = sat;
        1:       res_d.out_y = sat;
        default: res_d.out_z = sat;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= d_valid;
    end
  end

  assign out_strobe_o = strobe_q;
  assign result_o     = res_q;

  // Every result strobe comes from an accepted beat.
  a_strobe_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(accept, 7))
    else $error("result strobe without an accepted point seven cycles back");

  // Every accepted beat yields a result.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 out_strobe_o)
    else $error("accepted point produced no result");

  // A rotation write lands in the quaternion register on the next cycle.
  a_rotation_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && cfg_index_i == REG_ROTATION)
      |=> quat_q == $past(cfg_data_i))
    else $error("rotation register write lost");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import psrt_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned FLUSH_CYCLES = 20;
  localparam int unsigned PHASES       = 27;
  localparam int unsigned PHASE_POINTS = 50;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {JOB_POINT, JOB_CFG, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e            kind;
    point_t               pt;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    int unsigned          gap;
  } job_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  point_t               point     = '0;
  logic                 out_strobe;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Jobs waiting for the driver and transformed points waiting for their beat.
  job_t    xform_jobs_q[$];
  result_t xformed_q[$];

  job_t        cur_job;
  logic        job_loaded  = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned gap_max     = 0;
  logic        point_taken = 1'b0;
  logic        cfg_taken   = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned mismatch_count = 0;

  // Local copy of the transform registers, at their reset values.
  logic signed [COORD_W-1:0] scale_cfg [3] = '{SCALE_ONE, SCALE_ONE, SCALE_ONE};
  logic [CFG_W-1:0]          rot_cfg       = QUAT_IDENTITY;
  logic signed [COORD_W-1:0] offset_cfg [3] = '{32'sd0, 32'sd0, 32'sd0};

  point_scale_rotate_translate_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .point_i      (point),
    .out_strobe_o (out_strobe),
    .result_o     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Clamp to signed 32 bits and note any saturation.
  function automatic longint clamp_q16(longint x, inout logic ovf);
    if (x > longint'(C_MAX)) begin
      ovf = 1'b1;
      return longint'(C_MAX);
    end
    if (x < longint'(C_MIN)) begin
      ovf = 1'b1;
      return longint'(C_MIN);
    end
    return x;
  endfunction

  // Scale, rotate by the quaternion, translate. All shifts are floor shifts.
  function automatic result_t transform_point(point_t p);
    longint  pin [3];
    longint  v [3];
    longint  q [3];
    longint  c [3];
    longint  d [3];
    longint  res [3];
    longint  w;
    logic    ovf;
    result_t r;
    pin[0] = p.point_x;
    pin[1] = p.point_y;
    pin[2] = p.point_z;
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp_q16((pin[i] * longint'(scale_cfg[i])) >>> SCALE_SH, ovf);
    end
    w    = $signed(rot_cfg[63:48]);
    q[0] = $signed(rot_cfg[47:32]);
    q[1] = $signed(rot_cfg[31:16]);
    q[2] = $signed(rot_cfg[15:0]);
    // First cross product q x v, back to Q16.16.
    c[0] = (q[1] * v[2] - q[2] * v[1]) >>> CROSS1_SH;
    c[1] = (q[2] * v[0] - q[0] * v[2]) >>> CROSS1_SH;
    c[2] = (q[0] * v[1] - q[1] * v[0]) >>> CROSS1_SH;
    // Second cross product with the factor two folded into the shift.
    d[0] = (q[1] * c[2] - q[2] * c[1]) >>> CROSS2_SH;
    d[1] = (q[2] * c[0] - q[0] * c[2]) >>> CROSS2_SH;
    d[2] = (q[0] * c[1] - q[1] * c[0]) >>> CROSS2_SH;
    for (int i = 0; i < 3; i++) begin
      res[i] = clamp_q16(v[i] + ((w * c[i]) >>> CROSS2_SH) + d[i] + longint'(offset_cfg[i]),
                         ovf);
    end
    r.out_x    = 32'(res[0]);
    r.out_y    = 32'(res[1]);
    r.out_z    = 32'(res[2]);
    r.overflow = ovf;
    return r;
  endfunction

  // Mirror a register write; 32-bit registers keep the low half of the data.
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_SCALE_X:  scale_cfg[0]  = data[31:0];
      REG_SCALE_Y:  scale_cfg[1]  = data[31:0];
      REG_SCALE_Z:  scale_cfg[2]  = data[31:0];
      REG_ROTATION: rot_cfg       = data;
      REG_OFFSET_X: offset_cfg[0] = data[31:0];
      REG_OFFSET_Y: offset_cfg[1] = data[31:0];
      REG_OFFSET_Z: offset_cfg[2] = data[31:0];
      default: ;
    endcase
  endfunction

  task automatic push_point(input logic signed [COORD_W-1:0] x, y, z);
    job_t j;
    j.kind = JOB_POINT;
    j.pt   = '{point_x: x, point_y: y, point_z: z};
    j.idx  = '0;
    j.data = '0;
    j.gap  = $urandom_range(gap_max, 0);
    xform_jobs_q.push_back(j);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    job_t j;
    j.kind = JOB_CFG;
    j.pt   = '0;
    j.idx  = idx;
    j.data = data;
    j.gap  = $urandom_range(gap_max, 0);
    xform_jobs_q.push_back(j);
  endtask

  task automatic push_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.pt   = '0;
    j.idx  = '0;
    j.data = '0;
    j.gap  = 0;
    xform_jobs_q.push_back(j);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_extreme();
    case ($urandom_range(4, 0))
      0: return C_MAX;
      1: return C_MIN;
      2: return 32'sd0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  // Half the values within +-32.0, most of the rest full-range, some extremes.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9, 0))
      0: return pick_extreme();
      1, 2, 3, 4: return $urandom;
      default: return int'($urandom_range(32'h0040_0000, 0)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_scale();
    case ($urandom_range(5, 0))
      0: return pick_extreme();
      1: return $urandom;
      default: return int'($urandom_range(32'h0008_0000, 0)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_offset();
    case ($urandom_range(5, 0))
      0: return pick_extreme();
      1: return $urandom;
      default: return int'($urandom_range(32'h0080_0000, 0)) - 32'sh0040_0000;
    endcase
  endfunction

  // Unit quaternion from a random axis and angle, rounded toward zero in Q2.14.
  function automatic logic [CFG_W-1:0] unit_quat();
    real ax, ay, az, len, half, s;
    logic signed [QUAT_W-1:0] qw, qx, qy, qz;
    ax = real'(int'($urandom_range(2000, 0)) - 1000);
    ay = real'(int'($urandom_range(2000, 0)) - 1000);
    az = real'(int'($urandom_range(2000, 0)) - 1000);
    len = $sqrt(ax * ax + ay * ay + az * az);
    if (len < 1.0) begin
      ax  = 1.0;
      len = 1.0;
    end
    half = real'($urandom_range(6283, 0)) / 2000.0;
    s  = $sin(half) / len;
    qw = 16'($rtoi($cos(half) * 16384.0));
    qx = 16'($rtoi(ax * s * 16384.0));
    qy = 16'($rtoi(ay * s * 16384.0));
    qz = 16'($rtoi(az * s * 16384.0));
    return {qw, qx, qy, qz};
  endfunction

  function automatic logic [QUAT_W-1:0] quat_extreme();
    case ($urandom_range(4, 0))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_quat();
    case ($urandom_range(7, 0))
      0: return {$urandom, $urandom};
      1: return QUAT_IDENTITY;
      2: return {quat_extreme(), quat_extreme(), quat_extreme(), quat_extreme()};
      default: return unit_quat();
    endcase
  endfunction

  // Driver: one beat at a time, changed only at the falling edge.
  always @(negedge clk) begin : driver
    logic nx_start;
    logic nx_cfg;
    if (rst_n) begin
      if (!((start && !point_taken) || (cfg_valid && !cfg_taken))) begin
        nx_start = 1'b0;
        nx_cfg   = 1'b0;
        if (!job_loaded && xform_jobs_q.size() > 0) begin
          cur_job    = xform_jobs_q.pop_front();
          job_loaded = 1'b1;
          gap_left   = cur_job.gap;
        end
        if (job_loaded) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            case (cur_job.kind)
              JOB_POINT: begin
                nx_start   = 1'b1;
                point     <= cur_job.pt;
                job_loaded = 1'b0;
              end
              // Register writes only go out once the pipeline is empty.
              JOB_CFG: begin
                if (xformed_q.size() == 0) begin
                  nx_cfg     = 1'b1;
                  cfg_index <= cur_job.idx;
                  cfg_data  <= cur_job.data;
                  job_loaded = 1'b0;
                end
              end
              default: begin
                if (xformed_q.size() == 0) job_loaded = 1'b0;
              end
            endcase
          end
        end
        start     <= nx_start;
        cfg_valid <= nx_cfg;
      end
    end
  end

  // Monitor: check result beats, predict accepted points, mirror register writes.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (xformed_q.size() == 0) begin
          $error("result beat with no point outstanding: %h", result);
          mismatch_count++;
        end else begin
          want = xformed_q.pop_front();
          if (result.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
            mismatch_count++;
          end
          if (result.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, result.out_y);
            mismatch_count++;
          end
          if (result.out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, result.out_z);
            mismatch_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) xformed_q.push_back(transform_point(point));
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      point_taken <= start && !busy;
      cfg_taken   <= cfg_valid && cfg_ready;
    end
  end

  // Watchdog: too many cycles in a row without any beat moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    // Directed: field extremes under the reset transform.
    gap_max = 0;
    push_point(32'sd0, 32'sd0, 32'sd0);
    push_point(C_MAX, C_MIN, 32'sd1);
    push_point(C_MIN, C_MAX, -32'sd1);
    push_point(32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000);

    // Extreme scales: the scaling step saturates and negative products round down.
    push_cfg(REG_SCALE_X, {32'hFFFF_FFFF, C_MIN});
    push_cfg(REG_SCALE_Y, {32'h0000_0000, C_MAX});
    push_cfg(REG_SCALE_Z, {$urandom, 32'hFFFF_8000});
    push_point(C_MIN, C_MIN, C_MIN);
    push_point(C_MAX, C_MAX, C_MAX);
    push_point(-32'sd1, 32'sd1, 32'sd3);
    push_point(-32'sh0001_0000, 32'sd1, -32'sd3);

    // Non-unit quaternion at full negative scale, offsets at both limits.
    gap_max = 9;
    push_cfg(REG_SCALE_X, {$urandom, SCALE_ONE});
    push_cfg(REG_SCALE_Y, {$urandom, SCALE_ONE});
    push_cfg(REG_SCALE_Z, {$urandom, SCALE_ONE});
    push_cfg(REG_ROTATION, 64'h8000_8000_8000_8000);
    push_cfg(REG_OFFSET_X, {32'h0000_0000, C_MAX});
    push_cfg(REG_OFFSET_Y, {32'hFFFF_FFFF, C_MIN});
    push_cfg(REG_OFFSET_Z, {$urandom, 32'h0000_0000});
    push_point(C_MAX, C_MIN, C_MAX);
    push_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    push_point(32'sd0, 32'sd0, 32'sd0);
    push_cfg(REG_ROTATION, 64'h7FFF_7FFF_7FFF_7FFF);
    push_point(-32'sd1, -32'sd1, -32'sd1);
    push_point(C_MIN, 32'sd0, C_MAX);

    // Quarter turn about z, no offset, plus a write to the unused index.
    push_cfg(REG_ROTATION, 64'h2D41_0000_0000_2D41);
    push_cfg(REG_OFFSET_X, {$urandom, 32'h0000_0000});
    push_cfg(REG_OFFSET_Y, {$urandom, 32'h0000_0000});
    push_cfg(REG_UNUSED, {$urandom, $urandom});
    push_point(32'sh0001_0000, 32'sd0, 32'sd0);
    push_point(32'sd0, 32'sh0001_0000, 32'sd0);
    push_point(rand_coord(), rand_coord(), rand_coord());
    push_drain();

    // Random phases: a new register setting, then a run of points.
    for (int ph = 0; ph < PHASES; ph++) begin
      gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_SCALE_X, {$urandom, rand_scale()});
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_SCALE_Y, {$urandom, rand_scale()});
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_SCALE_Z, {$urandom, rand_scale()});
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_ROTATION, rand_quat());
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_OFFSET_X, {$urandom, rand_offset()});
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_OFFSET_Y, {$urandom, rand_offset()});
      if (ph == 0 || $urandom_range(1, 0)) push_cfg(REG_OFFSET_Z, {$urandom, rand_offset()});
      if ($urandom_range(5, 0) == 0) push_cfg(REG_UNUSED, {$urandom, $urandom});
      for (int n = 0; n < PHASE_POINTS; n++) begin
        push_point(rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(39, 0) == 0) push_drain();
      end
    end

    // Reset once, released on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last job to go out and every result beat to come back.
    do @(negedge clk);
    while (xform_jobs_q.size() != 0 || job_loaded || start || cfg_valid ||
           xformed_q.size() != 0);
    repeat (FLUSH_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && xformed_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/psrt_pkg.sv
rtl/core/psrt_scale.sv
rtl/core/psrt_cross.sv
rtl/core/point_scale_rotate_translate_core.sv
dv/tb.sv
